/* sv/mbf_pkg.sv */
// Shared types, codes and the CRC-16 byte step for the Modbus RTU master framer.
// No dependencies; the other files except mbf_if refer to this package by scoped names.
`timescale 1ns / 1ps

package mbf_pkg;

  // Largest register count accepted for a write-multiple request
  localparam int MAX_WRITE_REGS = 20;
  // Width of the count of payload bytes still due after a write-multiple header
  localparam int LEFT_W = $clog2(2 * MAX_WRITE_REGS + 1);

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Element index inside one job (up to nine result items)
  localparam int IDX_W = 4;

  // Modbus function codes
  localparam logic [7:0] FC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FC_WRITE_MANY = 8'h10;

  // Header lengths in bytes
  localparam logic [IDX_W-1:0] HDR_LEN_SHORT = 4'd6;
  localparam logic [IDX_W-1:0] HDR_LEN_LONG  = 4'd7;

  typedef enum logic [1:0] {
    FN_START = 2'd0,
    FN_DATA  = 2'd1,
    FN_RX    = 2'd2,
    FN_ACK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RQ_READ_HOLD  = 2'd0,
    RQ_WRITE_ONE  = 2'd1,
    RQ_WRITE_MANY = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    RK_TX      = 2'd0,
    RK_VERDICT = 2'd1,
    RK_REFUSE  = 2'd2
  } rkind_t;

  typedef enum logic [1:0] {
    JB_HDR    = 2'd0,
    JB_DATA   = 2'd1,
    JB_VERD   = 2'd2,
    JB_REFUSE = 2'd3
  } jkind_t;

  // One unit of work for the back end
  typedef struct packed {
    jkind_t      jkind;
    logic [7:0]  b0;        // slave address, or the data byte of a data job
    logic [7:0]  code;
    logic [15:0] reg_addr;
    logic [15:0] cv;
    logic        wr_many;   // header carries a byte count
    logic        close;     // CRC follows this job
    logic        prev;
    logic        ok;
    logic [7:0]  vcode;
    logic        parse;
    logic        ack;
  } job_t;

  // One result item
  typedef struct packed {
    rkind_t      result_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        prev_acked;
    logic        reply_ok;
    logic [7:0]  reply_code;
    logic        needs_read_parse;
    logic        ack_now;
  } res_t;

  // CRC-16 (reflected 0xA001) over one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (x[0]) begin
        x = (x >> 1) ^ 16'hA001;
      end else begin
        x = x >> 1;
      end
    end
    return x;
  endfunction

endpackage

/* sv/mbf_if.sv */
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing; widths follow the item fields.
`timescale 1ns / 1ps

interface mbf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  request_kind;
  logic [7:0]  slave_addr;
  logic [15:0] reg_addr;
  logic [15:0] count_or_value;
  logic [7:0]  data_byte;
  logic [7:0]  rx_byte;
  logic        rx_last;

  modport source (output valid, func, request_kind, slave_addr, reg_addr, count_or_value,
                  data_byte, rx_byte, rx_last, input ready);
  modport sink (input valid, func, request_kind, slave_addr, reg_addr, count_or_value,
                data_byte, rx_byte, rx_last, output ready);
endinterface

interface mbf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic        prev_acked;
  logic        reply_ok;
  logic [7:0]  reply_code;
  logic        needs_read_parse;
  logic        ack_now;

  modport source (output valid, result_kind, tx_byte, tx_last, prev_acked, reply_ok,
                  reply_code, needs_read_parse, ack_now, input ready);
  modport sink (input valid, result_kind, tx_byte, tx_last, prev_acked, reply_ok,
                reply_code, needs_read_parse, ack_now, output ready);
endinterface

/* sv/mbf_queue.sv */
// Short job queue between the front and back ends, in flip-flops.
// Depends on mbf_pkg (job_t, QDEPTH).
`timescale 1ns / 1ps

module mbf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbf_pkg::job_t push_job,
  output logic          full,
  output logic          q_valid,
  output mbf_pkg::job_t q_head,
  input  logic          pop
);

  mbf_pkg::job_t                   slot_r [mbf_pkg::QDEPTH];
  logic [mbf_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [mbf_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [mbf_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == mbf_pkg::QCNT_W'(mbf_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold job payloads
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mbf_pkg::QCNT_W'(mbf_pkg::QDEPTH))
    else $error("queue occupancy above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == mbf_pkg::QCNT_W'(mbf_pkg::QDEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with occupancy");

endmodule

/* sv/mbf_front.sv */
// Front end: accepts items, keeps acknowledge, target and receive state, and
// turns each item into at most one job. Depends on mbf_pkg and mbf_in_if.
`timescale 1ns / 1ps

module mbf_front (
  input  logic          clk,
  input  logic          rst_n,
  mbf_in_if.sink        in_chan,
  output logic          push,
  output mbf_pkg::job_t push_job,
  input  logic          q_full
);

  logic                        ack_r, ack_nxt;
  logic [7:0]                  target_r, target_nxt;
  logic [mbf_pkg::LEFT_W-1:0]  left_r, left_nxt;
  logic [15:0]                 rx_crc_r, rx_crc_nxt;
  logic [15:0]                 rx_tail_r, rx_tail_nxt;
  logic [15:0]                 rx_head_r, rx_head_nxt;
  logic [1:0]                  rx_cnt_r, rx_cnt_nxt;

  logic        acc;
  logic [7:0]  fcode;
  logic        ok;
  logic [7:0]  vcode;

  assign in_chan.ready = !q_full;
  assign acc           = in_chan.valid && in_chan.ready;

  // Function code for the request kind
  always_comb begin
    case (in_chan.request_kind)
      mbf_pkg::RQ_READ_HOLD:  fcode = mbf_pkg::FC_READ_HOLD;
      mbf_pkg::RQ_WRITE_ONE:  fcode = mbf_pkg::FC_WRITE_ONE;
      default:                fcode = mbf_pkg::FC_WRITE_MANY;
    endcase
  end

  // Receive path: shift the byte in, fold the older tail byte into the CRC
  always_comb begin
    rx_crc_nxt  = (rx_cnt_r >= 2'd2) ? mbf_pkg::crc_feed(rx_crc_r, rx_tail_r[15:8])
                                     : rx_crc_r;
    rx_head_nxt = (rx_cnt_r < 2'd2) ? {rx_head_r[7:0], in_chan.rx_byte} : rx_head_r;
    rx_tail_nxt = {rx_tail_r[7:0], in_chan.rx_byte};
    rx_cnt_nxt  = (rx_cnt_r == 2'd3) ? rx_cnt_r : rx_cnt_r + 2'd1;
    vcode       = (rx_cnt_nxt >= 2'd2) ? rx_head_nxt[7:0] : 8'h00;
    ok          = (rx_cnt_nxt == 2'd3)
               && (rx_head_nxt[15:8] == target_r)
               && (rx_tail_nxt[15:8] == rx_crc_nxt[7:0])
               && (rx_tail_nxt[7:0] == rx_crc_nxt[15:8]);
  end

  // Classify the item and build its job
  always_comb begin
    ack_nxt    = ack_r;
    target_nxt = target_r;
    left_nxt   = left_r;
    push       = 1'b0;
    push_job   = '0;
    case (in_chan.func)
      mbf_pkg::FN_START: begin
        if (in_chan.request_kind == mbf_pkg::RQ_WRITE_MANY &&
            in_chan.count_or_value > 16'(mbf_pkg::MAX_WRITE_REGS)) begin
          push           = 1'b1;
          push_job.jkind = mbf_pkg::JB_REFUSE;
        end else if (in_chan.request_kind == mbf_pkg::RQ_READ_HOLD ||
                     in_chan.request_kind == mbf_pkg::RQ_WRITE_ONE ||
                     in_chan.request_kind == mbf_pkg::RQ_WRITE_MANY) begin
          push              = 1'b1;
          push_job.jkind    = mbf_pkg::JB_HDR;
          push_job.b0       = in_chan.slave_addr;
          push_job.code     = fcode;
          push_job.reg_addr = in_chan.reg_addr;
          push_job.cv       = in_chan.count_or_value;
          push_job.wr_many  = (in_chan.request_kind == mbf_pkg::RQ_WRITE_MANY);
          push_job.close    = !(push_job.wr_many && in_chan.count_or_value != 16'h0000);
          push_job.prev     = ack_r;
          ack_nxt           = 1'b0;
          target_nxt        = in_chan.slave_addr;
          left_nxt          = push_job.wr_many
                            ? mbf_pkg::LEFT_W'({in_chan.count_or_value, 1'b0}) : '0;
        end
      end
      mbf_pkg::FN_DATA: begin
        if (left_r != '0) begin
          push           = 1'b1;
          push_job.jkind = mbf_pkg::JB_DATA;
          push_job.b0    = in_chan.data_byte;
          push_job.close = (left_r == mbf_pkg::LEFT_W'(1));
          left_nxt       = left_r - 1'b1;
        end
      end
      mbf_pkg::FN_RX: begin
        if (in_chan.rx_last) begin
          push           = 1'b1;
          push_job.jkind = mbf_pkg::JB_VERD;
          push_job.ok    = ok;
          push_job.vcode = vcode;
          push_job.parse = ok && (vcode == mbf_pkg::FC_READ_HOLD);
          if (ok && (vcode == mbf_pkg::FC_WRITE_ONE || vcode == mbf_pkg::FC_WRITE_MANY)) begin
            ack_nxt = 1'b1;
          end
          push_job.ack = ack_nxt;
        end
      end
      default: begin
        ack_nxt = 1'b1;
      end
    endcase
    push = push && acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_r     <= 1'b1;
      target_r  <= '0;
      left_r    <= '0;
      rx_crc_r  <= 16'hFFFF;
      rx_tail_r <= '0;
      rx_head_r <= '0;
      rx_cnt_r  <= '0;
    end else if (acc) begin
      ack_r    <= ack_nxt;
      target_r <= target_nxt;
      left_r   <= left_nxt;
      if (in_chan.func == mbf_pkg::FN_RX) begin
        // Clear the receive state after the final byte of a frame
        if (in_chan.rx_last) begin
          rx_crc_r  <= 16'hFFFF;
          rx_tail_r <= '0;
          rx_head_r <= '0;
          rx_cnt_r  <= '0;
        end else begin
          rx_crc_r  <= rx_crc_nxt;
          rx_tail_r <= rx_tail_nxt;
          rx_head_r <= rx_head_nxt;
          rx_cnt_r  <= rx_cnt_nxt;
        end
      end
    end
  end

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= mbf_pkg::LEFT_W'(2 * mbf_pkg::MAX_WRITE_REGS))
    else $error("payload byte count above the write limit");

endmodule

/* sv/mbf_back.sv */
// Back end: expands jobs into result items one per cycle while the output is not
// stalled, runs the transmit CRC and holds the result in an output register. Depends on mbf_pkg, mbf_out_if.
`timescale 1ns / 1ps

module mbf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  mbf_pkg::job_t q_head,
  output logic          pop,
  mbf_out_if.source     out_chan
);

  logic                       busy_r, busy_nxt;
  mbf_pkg::job_t              job_r, job_nxt;
  logic [mbf_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  mbf_pkg::res_t              res_r, res_nxt;

  mbf_pkg::job_t              cur;
  logic                       cur_v, adv, go;
  logic [mbf_pkg::IDX_W-1:0]  nb;
  logic                       is_payload, last_el;
  logic [7:0]                 pay_byte;
  logic [15:0]                crc_base;

  assign cur   = busy_r ? job_r : q_head;
  assign cur_v = busy_r || q_valid;
  assign adv   = !out_valid_r || out_chan.ready;
  assign go    = adv && cur_v;
  assign pop   = go && !busy_r;

  // Pick the element at the current index
  always_comb begin
    nb         = (cur.jkind == mbf_pkg::JB_HDR)
               ? (cur.wr_many ? mbf_pkg::HDR_LEN_LONG : mbf_pkg::HDR_LEN_SHORT)
               : mbf_pkg::IDX_W'(1);
    is_payload = (cur.jkind == mbf_pkg::JB_HDR || cur.jkind == mbf_pkg::JB_DATA)
               && (idx_r < nb);
    case (idx_r)
      4'd0:    pay_byte = cur.b0;
      4'd1:    pay_byte = cur.code;
      4'd2:    pay_byte = cur.reg_addr[15:8];
      4'd3:    pay_byte = cur.reg_addr[7:0];
      4'd4:    pay_byte = cur.cv[15:8];
      4'd5:    pay_byte = cur.cv[7:0];
      default: pay_byte = {cur.cv[6:0], 1'b0};
    endcase
    crc_base = (cur.jkind == mbf_pkg::JB_HDR && idx_r == '0) ? 16'hFFFF : crc_r;
    case (cur.jkind)
      mbf_pkg::JB_HDR, mbf_pkg::JB_DATA:
        last_el = cur.close ? (idx_r == nb + 1'b1) : (idx_r == nb - 1'b1);
      default:
        last_el = 1'b1;
    endcase
  end

  // Build the result item
  always_comb begin
    res_nxt = '0;
    case (cur.jkind)
      mbf_pkg::JB_HDR, mbf_pkg::JB_DATA: begin
        res_nxt.result_kind = mbf_pkg::RK_TX;
        if (is_payload) begin
          res_nxt.tx_byte    = pay_byte;
          res_nxt.prev_acked = (cur.jkind == mbf_pkg::JB_HDR) && (idx_r == '0) && cur.prev;
        end else if (idx_r == nb) begin
          res_nxt.tx_byte = crc_r[7:0];
        end else begin
          res_nxt.tx_byte = crc_r[15:8];
          res_nxt.tx_last = 1'b1;
        end
      end
      mbf_pkg::JB_VERD: begin
        res_nxt.result_kind      = mbf_pkg::RK_VERDICT;
        res_nxt.reply_ok         = cur.ok;
        res_nxt.reply_code       = cur.vcode;
        res_nxt.needs_read_parse = cur.parse;
        res_nxt.ack_now          = cur.ack;
      end
      default: begin
        res_nxt.result_kind = mbf_pkg::RK_REFUSE;
      end
    endcase
  end

  // Advance the job, CRC and output register
  always_comb begin
    busy_nxt      = busy_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
      if (is_payload) begin
        crc_nxt = mbf_pkg::crc_feed(crc_base, pay_byte);
      end
      if (last_el) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end else begin
        busy_nxt = 1'b1;
        idx_nxt  = idx_r + 1'b1;
        job_nxt  = cur;
      end
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      crc_r       <= 16'hFFFF;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (go) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.result_kind      = res_r.result_kind;
  assign out_chan.tx_byte          = res_r.tx_byte;
  assign out_chan.tx_last          = res_r.tx_last;
  assign out_chan.prev_acked       = res_r.prev_acked;
  assign out_chan.reply_ok         = res_r.reply_ok;
  assign out_chan.reply_code       = res_r.reply_code;
  assign out_chan.needs_read_parse = res_r.needs_read_parse;
  assign out_chan.ack_now          = res_r.ack_now;

  a_busy_multi: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (job_r.jkind == mbf_pkg::JB_HDR || job_r.jkind == mbf_pkg::JB_DATA)
               && idx_r != '0)
    else $error("single-item job left the back end busy");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pop)
    else $error("queue popped while a job is in progress");

  a_last_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.tx_last |-> res_r.result_kind == mbf_pkg::RK_TX
                                     && res_r.prev_acked == 1'b0)
    else $error("frame end marked on a non-transmit item");

endmodule

/* sv/modbus_rtu_master_framer.sv */
// Modbus RTU master framer and reply checker, top level.
// Depends on mbf_pkg, mbf_if, mbf_queue, mbf_front and mbf_back.
// A request start yields 7 to 9 transmit items (header, byte count for write-multiple,
// CRC low then high unless write data follows), one item per cycle while the output is
// not stalled; a write data byte yields one item, or three when it closes the frame; a
// final received byte yields one verdict item; an over-long write-multiple yields one
// refusal item. The front end takes one input item per cycle while its 4-entry job
// queue has room, and the back end serializer emitting one result per cycle (when the
// output does not stall) sets the sustained rate, so request starts can queue while a
// frame is still being sent. The first result item passes through the job queue and
// the back-end output register. Acknowledge resets to set.
`timescale 1ns / 1ps

module modbus_rtu_master_framer (
  input  logic       clk,
  input  logic       rst_n,
  mbf_in_if.sink     in_chan,
  mbf_out_if.source  out_chan
);

  logic          push, q_full, q_valid, pop;
  mbf_pkg::job_t push_job, q_head;

  // Classify items and keep request/receive state
  mbf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // Decouple front and back
  mbf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop)
  );

  // Serialize jobs into result items
  mbf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
